@@ sv/bounded_set_min_max_gap_tracker_core_defines.svh @@
// Assertion macros shared by the tracker modules.
// Each macro expects the asserting module to have clk and rst_n in scope.
`ifndef BOUNDED_SET_MIN_MAX_GAP_TRACKER_CORE_DEFINES_SVH
`define BOUNDED_SET_MIN_MAX_GAP_TRACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bsmg_pkg.sv @@
package bsmg_pkg;

  localparam int MAX_VALUES = 256;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 9;
  localparam int OUT_CNT_W  = 9;
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PEND_W     = $clog2(MAX_VALUES + 2);
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // Register index, taken from paddr[2].
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  // Operation codes.
  localparam logic OP_SINGLE = 1'b0;
  localparam logic OP_RUN    = 1'b1;

  // One insertion traveling along the row of cells.
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] gap;
  } tok_t;

  // Unsigned distance between two signed values, exact over the full range.
  function automatic logic [DATA_W-1:0] span_dist(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
    if ($signed(a) >= $signed(b)) begin
      return a - b;
    end else begin
      return b - a;
    end
  endfunction

endpackage

@@ sv/bsmg_if.sv @@
interface bsmg_req_if;
  import bsmg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] run_end;

  modport source (output valid, output operation, output value, output run_end,
                  input ready);
  modport sink (input valid, input operation, input value, input run_end,
                output ready);
endinterface

interface bsmg_rsp_if;
  import bsmg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 full_error;
  logic                 too_few;
  logic [OUT_CNT_W-1:0] stored_count;
  logic [DATA_W-1:0]    shortest_span;
  logic [DATA_W-1:0]    longest_span;

  modport source (output valid, output full_error, output too_few, output stored_count,
                  output shortest_span, output longest_span, input ready);
  modport sink (input valid, input full_error, input too_few, input stored_count,
                input shortest_span, input longest_span, output ready);
endinterface

@@ sv/bsmg_cell.sv @@
// One slot of the set. A passing insertion is compared against the held value
// when this slot lies below its target slot, and is stored when it reaches it.
module bsmg_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bsmg_pkg::IDX_W-1:0] cell_idx,
  input  bsmg_pkg::tok_t            tok_i,
  output bsmg_pkg::tok_t            tok_o
);
  import bsmg_pkg::*;

  logic [DATA_W-1:0] held_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              cmp_en;
  logic [DATA_W-1:0] gap_cand;

  always_comb begin
    cmp_en   = tok_i.vld && (cell_idx < tok_i.slot);
    gap_cand = span_dist(tok_i.value, held_r);
    tok_nxt  = tok_i;
    if (cmp_en && (gap_cand < tok_i.gap)) begin
      tok_nxt.gap = gap_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i.vld && (tok_i.slot == cell_idx)) begin
      held_r <= tok_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ sv/bsmg_ctrl.sv @@
`include "bounded_set_min_max_gap_tracker_core_defines.svh"

// Sequencer: takes a request, issues one insertion per cycle into the row of
// cells, keeps count and range, folds returning gaps and registers the result.
module bsmg_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bsmg_pkg::CAP_W-1:0] capacity,
  bsmg_req_if.sink                  in_ch,
  bsmg_rsp_if.source                out_ch,
  output bsmg_pkg::tok_t            tok_inj,
  input  bsmg_pkg::tok_t            tok_exit
);
  import bsmg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0]    lo_r, lo_nxt;
  logic [DATA_W-1:0]    hi_r, hi_nxt;
  logic [DATA_W-1:0]    gap_r, gap_nxt;
  logic [DATA_W-1:0]    cur_r, cur_nxt;
  logic [DATA_W-1:0]    end_r, end_nxt;
  logic                 up_r, up_nxt;
  logic                 full_r, full_nxt;
  logic [PEND_W-1:0]    pend_r, pend_nxt;
  tok_t                 tok_inj_r, tok_inj_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_full_r, out_full_nxt;
  logic                 out_few_r, out_few_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [DATA_W-1:0]    out_short_r, out_short_nxt;
  logic [DATA_W-1:0]    out_long_r, out_long_nxt;
  logic                 in_acc;
  logic                 lim_hit;
  logic                 few;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign lim_hit     = (CMP_W'(count_r) >= CMP_W'(capacity)) ||
                       (CMP_W'(count_r) >= CMP_W'(MAX_VALUES));
  assign few         = (count_r < CNT_W'(2));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    gap_nxt       = gap_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    up_nxt        = up_r;
    full_nxt      = full_r;
    tok_inj_nxt   = tok_inj_r;
    tok_inj_nxt.vld = 1'b0;
    out_valid_nxt = out_valid_r;
    out_full_nxt  = out_full_r;
    out_few_nxt   = out_few_r;
    out_cnt_nxt   = out_cnt_r;
    out_short_nxt = out_short_r;
    out_long_nxt  = out_long_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          full_nxt = 1'b0;
          cur_nxt  = in_ch.value;
          if (in_ch.operation == OP_RUN) begin
            end_nxt   = in_ch.run_end;
            up_nxt    = (in_ch.value < in_ch.run_end);
            state_nxt = (in_ch.value == in_ch.run_end) ? S_DRAIN : S_RUN;
          end else begin
            end_nxt   = in_ch.value;
            up_nxt    = 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (lim_hit) begin
          full_nxt  = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          tok_inj_nxt.vld   = 1'b1;
          tok_inj_nxt.value = cur_r;
          tok_inj_nxt.slot  = count_r[IDX_W-1:0];
          tok_inj_nxt.gap   = '1;
          count_nxt         = count_r + 1'b1;
          if (count_r == '0) begin
            lo_nxt = cur_r;
            hi_nxt = cur_r;
          end else begin
            if ($signed(cur_r) < $signed(lo_r)) begin
              lo_nxt = cur_r;
            end
            if ($signed(cur_r) > $signed(hi_r)) begin
              hi_nxt = cur_r;
            end
          end
          if (cur_r == end_r) begin
            state_nxt = S_DRAIN;
          end else begin
            cur_nxt = up_r ? (cur_r + 1'b1) : (cur_r - 1'b1);
          end
        end
      end
      S_DRAIN: begin
        if ((pend_r == '0) && (!out_valid_r || out_ch.ready)) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = full_r;
          out_few_nxt   = few;
          out_cnt_nxt   = OUT_CNT_W'(count_r);
          out_short_nxt = few ? '0 : gap_r;
          out_long_nxt  = few ? '0 : (hi_r - lo_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (tok_exit.vld && (tok_exit.gap < gap_r)) begin
      gap_nxt = tok_exit.gap;
    end
    pend_nxt = pend_r + PEND_W'(tok_inj_nxt.vld) - PEND_W'(tok_exit.vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      lo_r          <= '0;
      hi_r          <= '0;
      gap_r         <= '1;
      pend_r        <= '0;
      tok_inj_r.vld <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      gap_r       <= gap_nxt;
      pend_r      <= pend_nxt;
      tok_inj_r   <= tok_inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    end_r       <= end_nxt;
    up_r        <= up_nxt;
    full_r      <= full_nxt;
    out_full_r  <= out_full_nxt;
    out_few_r   <= out_few_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_short_r <= out_short_nxt;
    out_long_r  <= out_long_nxt;
  end

  assign tok_inj              = tok_inj_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.full_error    = out_full_r;
  assign out_ch.too_few       = out_few_r;
  assign out_ch.stored_count  = out_cnt_r;
  assign out_ch.shortest_span = out_short_r;
  assign out_ch.longest_span  = out_long_r;

  `BSMG_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE, "request accepted but sequencer stayed idle")
  `BSMG_ASSERT_NEXT(a_insert_counts, tok_inj_nxt.vld, count_r == $past(count_r) + 1'b1, "insertion issued without count increment")
  `BSMG_ASSERT_NOW(a_result_after_drain, (state_r == S_DRAIN) && (state_nxt == S_IDLE), pend_r == '0, "result loaded while insertions still in the row")
  `BSMG_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= CNT_W'(MAX_VALUES), "held count exceeds the number of cells")

endmodule

@@ sv/bounded_set_min_max_gap_tracker_core.sv @@
// Bounded set tracker. The block holds up to a programmed number of signed 32-bit values
// (repeats allowed) and, for every request, reports how many values are held, the smallest
// distance between any two of them and the largest minus the smallest, the spans as unsigned
// 32-bit quantities. A request adds one value, or adds an inclusive run that steps by one
// from its start toward its end; a run with equal ends adds nothing. Values that no longer
// fit are dropped and the result is flagged with full_error; values added before that stay.
// When fewer than two values are held, too_few is set and both spans read as zero. The
// capacity register (byte address 0, 9 bits) resets to zero, so every add is refused until
// it is written; a capacity above the number of cells acts as the number of cells, and
// lowering it below the current count keeps the held values but refuses later adds.
// Storage is a row of MAX_VALUES cells, one value per cell. Each accepted value becomes an
// insertion that enters the first cell and moves one cell per cycle, picking up its distance
// to every value already held and writing itself into the next free cell; the running
// minimum gap is folded in as it leaves the last cell. A request that adds values issues one
// insertion per cycle, then waits while the last insertion crosses the whole row, and then
// loads its result; a request that adds nothing issues no insertion. The block works on one
// request at a time; a new request is taken while the previous result is still waiting on
// the output register, and a receiver stall adds its length on top once the next result is
// ready behind it.
module bounded_set_min_max_gap_tracker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsmg_pkg::CFG_AW-1:0] paddr,
  input  logic [bsmg_pkg::CFG_DW-1:0] pwdata,
  output logic [bsmg_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  bsmg_req_if.sink                    in_ch,
  bsmg_rsp_if.source                  out_ch
);
  import bsmg_pkg::*;

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic             cfg_wr;
  tok_t             chain [MAX_VALUES+1];

  // The configuration port never stalls. Only bit 2 of the address selects a register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_wr && (paddr[2] == CFG_IDX_CAPACITY)) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Reads return the capacity register; unmapped addresses read as zero.
  assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? CFG_DW'(capacity_r) : '0;

  // Sequencer: owns the handshakes, the count, the range and the result register.
  bsmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .tok_inj  (chain[0]),
    .tok_exit (chain[MAX_VALUES])
  );

  // The row of cells. Cell i holds the value written in slot i and passes each
  // insertion on to cell i+1 in the next cycle.
  for (genvar gi = 0; gi < MAX_VALUES; gi++) begin : g_cell
    bsmg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(gi)),
      .tok_i    (chain[gi]),
      .tok_o    (chain[gi+1])
    );
  end

endmodule
